// ===== src/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// Anchor chaining score - shared package
// Widths, fixed-point constants and the structs passed between the ring
// cells, the link unit and the top level.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned PosW   = 31;
  localparam int unsigned ScoreW = 31;
  localparam int unsigned BaseW  = 8;
  localparam int unsigned DiffW  = 32;
  localparam int unsigned ValW   = 35;
  localparam int unsigned SumW   = 32;
  localparam int unsigned T1W    = 33;
  localparam int unsigned GapQW  = 25;
  localparam int unsigned GapRW  = 7;
  localparam int unsigned T2W    = 15;
  localparam int unsigned PenLoW = 8;

  // floor(gap / 100) for gap below 2^31 is (gap * GapRecip) >> GapShift.
  localparam logic [31:0]  GapRecip  = 32'd2748779070;
  localparam int unsigned  GapShift  = 38;
  localparam int unsigned  GapProdW  = 63;
  localparam logic [6:0]   Hundred   = 7'd100;
  // floor(t / 100) for t below 2^15 is (t * PenRecip) >> PenShift.
  localparam logic [15:0]  PenRecip  = 16'd41944;
  localparam int unsigned  PenShift  = 22;
  localparam int unsigned  PenProdW  = 31;

  localparam logic [BaseW-1:0]  BaseReset = 8'd15;
  localparam logic [ScoreW-1:0] ScoreMax  = '1;

  // Registers between the link unit's inputs and its result.
  localparam int unsigned LinkLat = 7;
  localparam int unsigned DrainW  = $clog2(LinkLat);

  typedef struct packed {
    logic [PosW-1:0]   ref_pos;
    logic [PosW-1:0]   query_pos;
    logic [ScoreW-1:0] score;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic insert;
  } ring_ctl_t;

  typedef struct packed {
    logic             issue;
    logic [PosW-1:0]  ref_pos;
    logic [PosW-1:0]  query_pos;
    logic [BaseW-1:0] base;
  } probe_t;

  typedef struct packed {
    logic                   ok;
    logic signed [ValW-1:0] value;
  } link_res_t;

endpackage

// ===== src/acs_if.sv =====
// ----------------------------------------------------------------------------
// Anchor chaining score - channel interfaces
// Valid/ready channels for anchor words in and score words out.
// ----------------------------------------------------------------------------
interface acs_in_if;
  import acs_pkg::*;

  logic            valid;
  logic            ready;
  logic [PosW-1:0] ref_pos;
  logic [PosW-1:0] query_pos;
  logic            chain_start;

  modport source (output valid, ref_pos, query_pos, chain_start, input ready);
  modport sink   (input valid, ref_pos, query_pos, chain_start, output ready);
endinterface

interface acs_out_if;
  import acs_pkg::*;

  logic              valid;
  logic              ready;
  logic [ScoreW-1:0] chain_score;
  logic              score_saturated;

  modport source (output valid, chain_score, score_saturated, input ready);
  modport sink   (input valid, chain_score, score_saturated, output ready);
endinterface

// ===== src/acs_cell.sv =====
// ----------------------------------------------------------------------------
// Anchor chaining score - window cell
// Holds one window entry and passes it to its neighbour on every shift.
// ----------------------------------------------------------------------------
module acs_cell (
  input  logic               clk_i,
  input  acs_pkg::ring_ctl_t ctl_i,
  input  acs_pkg::entry_t    neigh_i,
  input  acs_pkg::entry_t    new_i,
  output acs_pkg::entry_t    entry_o
);
  import acs_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  assign entry_d = ctl_i.insert ? new_i : neigh_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== src/acs_link.sv =====
// ----------------------------------------------------------------------------
// Anchor chaining score - link unit
// Seven-stage pipeline giving the value of linking one predecessor entry
// to the current anchor: score + min(dx, dy, k) - floor(k * |dy - dx| / 100).
// ----------------------------------------------------------------------------
module acs_link (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acs_pkg::probe_t    probe_i,
  input  acs_pkg::entry_t    pred_i,
  output acs_pkg::link_res_t res_o
);
  import acs_pkg::*;

  // Stage valid bits; after stage 1, set only for a predecessor that counts.
  logic [LinkLat-1:0] ok_q;
  logic               ok2_d;

  // Stage 1
  logic signed [DiffW-1:0] s1_dx_q, s1_dy_q;
  logic [ScoreW-1:0]       s1_score_q;
  logic [BaseW-1:0]        s1_base_q;
  // Stage 2
  logic [PosW-1:0]   min_d;
  logic [DiffW-1:0]  diff_d, diff_abs_d;
  logic [BaseW-1:0]  bonus_d;
  logic [BaseW-1:0]  s2_bonus_q, s2_base_q;
  logic [PosW-1:0]   s2_gap_q;
  logic [ScoreW-1:0] s2_score_q;
  // Stage 3
  logic [GapProdW-1:0] gap_prod_d;
  logic [GapQW-1:0]    s3_gq_q;
  logic [PosW-1:0]     s3_gap_q;
  logic [BaseW-1:0]    s3_bonus_q, s3_base_q;
  logic [ScoreW-1:0]   s3_score_q;
  // Stage 4
  logic [DiffW-1:0]  gq_x100_d, grem_d;
  logic [GapRW-1:0]  s4_gr_q;
  logic [T1W-1:0]    s4_t1_q;
  logic [BaseW-1:0]  s4_bonus_q, s4_base_q;
  logic [ScoreW-1:0] s4_score_q;
  // Stage 5
  logic [T2W-1:0]    s5_t2_q;
  logic [T1W-1:0]    s5_t1_q;
  logic [BaseW-1:0]  s5_bonus_q;
  logic [ScoreW-1:0] s5_score_q;
  // Stage 6
  logic [PenProdW-1:0] pen_prod_d;
  logic [PenLoW-1:0]   s6_pen_q;
  logic [SumW-1:0]     s6_sum_q;
  logic [T1W-1:0]      s6_t1_q;
  // Stage 7
  logic signed [ValW-1:0] s7_val_q;

  // A predecessor counts only when it lies strictly before on both axes.
  assign ok2_d = ok_q[0] && !s1_dx_q[DiffW-1] && (s1_dx_q != '0)
                         && !s1_dy_q[DiffW-1] && (s1_dy_q != '0);

  assign min_d   = (s1_dx_q < s1_dy_q) ? s1_dx_q[PosW-1:0] : s1_dy_q[PosW-1:0];
  assign bonus_d = (min_d < PosW'(s1_base_q)) ? min_d[BaseW-1:0] : s1_base_q;
  assign diff_d     = s1_dy_q - s1_dx_q;
  assign diff_abs_d = diff_d[DiffW-1] ? (DiffW'(0) - diff_d) : diff_d;

  assign gap_prod_d = GapProdW'(s2_gap_q) * GapProdW'(GapRecip);
  assign gq_x100_d  = DiffW'(s3_gq_q) * DiffW'(Hundred);
  assign grem_d     = DiffW'(s3_gap_q) - gq_x100_d;
  assign pen_prod_d = PenProdW'(s5_t2_q) * PenProdW'(PenRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= '0;
    end else begin
      ok_q <= {ok_q[LinkLat-2:1], ok2_d, probe_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q    <= signed'({1'b0, probe_i.ref_pos}   - {1'b0, pred_i.ref_pos});
    s1_dy_q    <= signed'({1'b0, probe_i.query_pos} - {1'b0, pred_i.query_pos});
    s1_score_q <= pred_i.score;
    s1_base_q  <= probe_i.base;

    s2_bonus_q <= bonus_d;
    s2_gap_q   <= diff_abs_d[PosW-1:0];
    s2_score_q <= s1_score_q;
    s2_base_q  <= s1_base_q;

    s3_gq_q    <= gap_prod_d[GapProdW-1 -: GapQW];
    s3_gap_q   <= s2_gap_q;
    s3_bonus_q <= s2_bonus_q;
    s3_base_q  <= s2_base_q;
    s3_score_q <= s2_score_q;

    s4_gr_q    <= grem_d[GapRW-1:0];
    s4_t1_q    <= T1W'(s3_gq_q) * T1W'(s3_base_q);
    s4_bonus_q <= s3_bonus_q;
    s4_base_q  <= s3_base_q;
    s4_score_q <= s3_score_q;

    s5_t2_q    <= T2W'(s4_gr_q) * T2W'(s4_base_q);
    s5_t1_q    <= s4_t1_q;
    s5_bonus_q <= s4_bonus_q;
    s5_score_q <= s4_score_q;

    s6_pen_q   <= pen_prod_d[PenShift +: PenLoW];
    s6_sum_q   <= SumW'(s5_score_q) + SumW'(s5_bonus_q);
    s6_t1_q    <= s5_t1_q;

    s7_val_q   <= signed'(ValW'(s6_sum_q)) - signed'(ValW'(s6_t1_q))
                - signed'(ValW'(s6_pen_q));
  end

  assign res_o.ok    = ok_q[LinkLat-1];
  assign res_o.value = s7_val_q;

endmodule

// ===== src/anchor_chaining_score.sv =====
// ----------------------------------------------------------------------------
// Anchor chaining score - top level
// Scores sorted seed anchors against a window of recent anchors held in a
// ring of cells that rotates past one pipelined link unit.
// ----------------------------------------------------------------------------
//   channel   direction  handshake           word
//   in_i      in         valid / ready       ref_pos, query_pos, chain_start
//   out_o     out        valid / ready       chain_score, score_saturated
//   cfg       in         cfg_we_i            base_score (cfg_wdata_i)
//
// An anchor occupies the block while it is accepted, while the ring rotates
// each entry past the link unit, while that unit's pipeline empties, and
// while the entry and the result are stored. The output register lets the
// next anchor in while a score waits; the block stalls only when a new
// score is ready and the old one is not taken. Reset empties the window and
// sets base_score to 15; no clearing pass.
// ----------------------------------------------------------------------------
module anchor_chaining_score #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [acs_pkg::BaseW-1:0] cfg_wdata_i,
  acs_in_if.sink                    in_i,
  acs_out_if.source                 out_o
);
  import acs_pkg::*;

  localparam int unsigned FillW = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {StIdle, StScan, StDrain, StDone} state_e;

  state_e             state_q;
  logic [FillW-1:0]   scan_q;
  logic [FillW-1:0]   fill_q;
  logic [DrainW-1:0]  drain_q;
  logic [BaseW-1:0]   base_q;
  logic [PosW-1:0]    ref_q, query_q;
  logic signed [ValW-1:0] best_q;
  logic               out_valid_q;
  logic [ScoreW-1:0]  out_score_q;
  logic               out_sat_q;

  logic               in_acc;
  logic               out_free;
  logic               sat_d;
  logic [ScoreW-1:0]  score_d;
  logic               issue_d;
  ring_ctl_t          ring_ctl;
  entry_t             new_entry;
  entry_t             cell_q [WINDOW];
  probe_t             probe;
  link_res_t          link_res;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign sat_d   = best_q > signed'(ValW'(ScoreMax));
  assign score_d = sat_d ? ScoreMax : best_q[ScoreW-1:0];

  // The entry leaving the last cell during scan step t sat in cell
  // WINDOW-1-t; the filled cells are the lowest fill_q ones.
  assign issue_d = (state_q == StScan) &&
                   (({1'b0, scan_q} + {1'b0, fill_q}) >= (FillW + 1)'(WINDOW));

  assign ring_ctl.shift  = (state_q == StScan) || ((state_q == StDone) && out_free);
  assign ring_ctl.insert = (state_q == StDone);

  assign new_entry.ref_pos   = ref_q;
  assign new_entry.query_pos = query_q;
  assign new_entry.score     = score_d;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    ring_ctl_t cell_ctl;
    if (i == 0) begin : g_head
      assign cell_ctl = ring_ctl;
      acs_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (cell_ctl),
        .neigh_i (cell_q[WINDOW-1]),
        .new_i   (new_entry),
        .entry_o (cell_q[i])
      );
    end else begin : g_body
      assign cell_ctl.shift  = ring_ctl.shift;
      assign cell_ctl.insert = 1'b0;
      acs_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (cell_ctl),
        .neigh_i (cell_q[i-1]),
        .new_i   (new_entry),
        .entry_o (cell_q[i])
      );
    end
  end

  assign probe.issue     = issue_d;
  assign probe.ref_pos   = ref_q;
  assign probe.query_pos = query_q;
  assign probe.base      = base_q;

  acs_link u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .probe_i (probe),
    .pred_i  (cell_q[WINDOW-1]),
    .res_o   (link_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      fill_q      <= '0;
      drain_q     <= '0;
      base_q      <= BaseReset;
      ref_q       <= '0;
      query_q     <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      out_score_q <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      // A finished score takes the output register as the old word leaves.
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (link_res.ok && (link_res.value > best_q)) begin
        best_q <= link_res.value;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            ref_q   <= in_i.ref_pos;
            query_q <= in_i.query_pos;
            best_q  <= signed'(ValW'(base_q));
            scan_q  <= '0;
            if (in_i.chain_start) begin
              fill_q <= '0;
            end
            state_q <= StScan;
          end
        end
        StScan: begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == FillW'(WINDOW - 1)) begin
            drain_q <= '0;
            state_q <= StDrain;
          end
        end
        StDrain: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == DrainW'(LinkLat - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_score_q <= score_d;
            out_sat_q   <= sat_d;
            if (fill_q != FillW'(WINDOW)) begin
              fill_q <= fill_q + 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_i.ready            = (state_q == StIdle);
  assign out_o.valid           = out_valid_q;
  assign out_o.chain_score     = out_score_q;
  assign out_o.score_saturated = out_sat_q;

endmodule

// ===== src/acs_checker.sv =====
// ----------------------------------------------------------------------------
// Anchor chaining score - port checker
// Watches the top level's ports and flags handshake and score violations.
// ----------------------------------------------------------------------------
module acs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic [acs_pkg::BaseW-1:0]  cfg_wdata_i,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [acs_pkg::ScoreW-1:0] out_score_i,
  input logic                       out_sat_i
);
  import acs_pkg::*;

  // Mirror of the base score register, seen from the configuration port.
  logic [BaseW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_score_i)
                                    && $stable(out_sat_i))
    else $error("score word changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("anchor accepted while another is being scored");

  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_sat_i |-> out_score_i == ScoreMax)
    else $error("saturated score is not at the top of its range");

  a_score_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_score_i >= ScoreW'(base_q))
    else $error("score below the base score");

endmodule

bind anchor_chaining_score acs_checker u_acs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_score_i (out_o.chain_score),
  .out_sat_i   (out_o.score_saturated)
);

// ===== bench/anchor_chaining_score_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Anchor chaining score - scoreboard
// Watches the anchor and score channels and the base_score write port, keeps
// its own window of recent anchors, and checks every score word in order.
// ----------------------------------------------------------------------------
module anchor_chaining_score_checker #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [acs_pkg::BaseW-1:0] cfg_wdata_i,
  acs_in_if                         anchor_ch,
  acs_out_if                        score_ch,
  output int                        outstanding_o,
  output int                        mismatches_o
);
  import acs_pkg::*;

  localparam longint ScoreCeil = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              saturated;
  } score_word_t;

  logic [PosW-1:0]   win_ref   [WINDOW];
  logic [PosW-1:0]   win_query [WINDOW];
  logic [ScoreW-1:0] win_score [WINDOW];
  int unsigned       held;
  int unsigned       wr_slot;
  logic [BaseW-1:0]  base_k;
  score_word_t       expected_scores [$];
  int                mismatches = 0;

  assign mismatches_o = mismatches;

  // Scores one anchor against the live part of the window, then stores it.
  function automatic score_word_t score_anchor(input logic [PosW-1:0] rpos,
                                               input logic [PosW-1:0] qpos,
                                               input logic            start);
    longint      k;
    longint      best;
    longint      dx;
    longint      dy;
    longint      bonus;
    longint      gap;
    longint      link;
    score_word_t res;
    k    = longint'(base_k);
    best = k;
    if (start) begin
      held    = 0;
      wr_slot = 0;
    end
    for (int unsigned i = 0; i < held; i++) begin
      dx = longint'(rpos) - longint'(win_ref[i]);
      dy = longint'(qpos) - longint'(win_query[i]);
      if (dx > 0 && dy > 0) begin
        bonus = (dx < dy) ? dx : dy;
        if (bonus > k) bonus = k;
        gap = (dy > dx) ? dy - dx : dx - dy;
        link = longint'(win_score[i]) + bonus - (k * gap) / 100;
        if (link > best) best = link;
      end
    end
    res.saturated = 1'b0;
    if (best > ScoreCeil) begin
      best          = ScoreCeil;
      res.saturated = 1'b1;
    end
    res.score          = best[ScoreW-1:0];
    win_ref[wr_slot]   = rpos;
    win_query[wr_slot] = qpos;
    win_score[wr_slot] = res.score;
    wr_slot            = (wr_slot + 1) % WINDOW;
    if (held < WINDOW) held++;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_word_t want;
    if (!rst_ni) begin
      held    = 0;
      wr_slot = 0;
      base_k  = BaseReset;
      expected_scores.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) base_k = cfg_wdata_i;
      if (anchor_ch.valid && anchor_ch.ready) begin
        expected_scores.push_back(score_anchor(anchor_ch.ref_pos, anchor_ch.query_pos,
                                               anchor_ch.chain_start));
      end
      if (score_ch.valid && score_ch.ready) begin
        if (expected_scores.size() == 0) begin
          $error("chain_score: word with no anchor waiting, expected none, actual %0d",
                 score_ch.chain_score);
          mismatches++;
        end else begin
          want = expected_scores.pop_front();
          if (score_ch.chain_score !== want.score) begin
            $error("chain_score: expected %0d, actual %0d", want.score,
                   score_ch.chain_score);
            mismatches++;
          end
          if (score_ch.score_saturated !== want.saturated) begin
            $error("score_saturated: expected %0b, actual %0b", want.saturated,
                   score_ch.score_saturated);
            mismatches++;
          end
        end
      end
      outstanding_o <= expected_scores.size();
    end
  end

endmodule

// ===== bench/anchor_chaining_score_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Anchor chaining score - testbench top
// Drives directed corner anchors and then phases of random chains under a
// range of base_score values, with random idling on both channels.
// ----------------------------------------------------------------------------
module anchor_chaining_score_tb;
  import acs_pkg::*;

  localparam int unsigned WINDOW       = 16;
  localparam int unsigned PhaseLen     = 200;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned CalmPhase    = 3;
  localparam int unsigned IdlePct      = 7;
  localparam int unsigned SettleCycles = 2 * (WINDOW + 9);
  localparam int unsigned TimeoutNs    = 1_000_000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [BaseW-1:0] cfg_wdata;
  logic             calm;
  int               outstanding;
  int               mismatches;
  logic [PosW-1:0]  cur_ref;
  logic [PosW-1:0]  cur_query;

  acs_in_if  anchor_ch ();
  acs_out_if score_ch ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  anchor_chaining_score #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (anchor_ch),
    .out_o      (score_ch)
  );

  anchor_chaining_score_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .anchor_ch    (anchor_ch),
    .score_ch     (score_ch),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches)
  );

  // Score sink: stalls now and then, never during the calm phase.
  initial begin
    score_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      score_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic send_anchor(input logic [PosW-1:0] rpos, input logic [PosW-1:0] qpos,
                             input logic start);
    while (!calm && $urandom_range(99) < IdlePct) begin
      anchor_ch.valid <= 1'b0;
      @(posedge clk);
    end
    anchor_ch.valid       <= 1'b1;
    anchor_ch.ref_pos     <= rpos;
    anchor_ch.query_pos   <= qpos;
    anchor_ch.chain_start <= start;
    do @(posedge clk); while (!anchor_ch.ready);
  endtask

  // The scoreboard count is registered, so it lags the words that move.
  task automatic drain();
    anchor_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_base(input logic [BaseW-1:0] k);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed chains that climb on both axes, with some anchors
  // that step back on one axis and some that are pure noise.
  task automatic send_random_anchor();
    int unsigned     pick;
    int              step;
    int              skew;
    int              rise;
    logic [PosW-1:0] rpos;
    logic [PosW-1:0] qpos;
    logic            start;
    pick  = $urandom_range(99);
    start = 1'b0;
    if (pick < 12) begin
      rpos  = PosW'($urandom);
      qpos  = PosW'($urandom);
      start = ($urandom_range(7) == 0);
    end else if (pick < 18) begin
      if ($urandom_range(1) == 1) begin
        rpos = cur_ref - PosW'($urandom_range(20));
        qpos = cur_query + PosW'($urandom_range(20));
      end else begin
        rpos = cur_ref + PosW'($urandom_range(20));
        qpos = cur_query - PosW'($urandom_range(20));
      end
    end else if ($urandom_range(29) == 0) begin
      cur_ref   = PosW'($urandom);
      cur_query = PosW'($urandom);
      rpos      = cur_ref;
      qpos      = cur_query;
      start     = 1'b1;
    end else begin
      step = ($urandom_range(4) == 0) ? int'($urandom_range(400)) : int'($urandom_range(40));
      case ($urandom_range(9))
        0:       skew = int'($urandom_range(10000)) - 5000;
        1, 2:    skew = int'($urandom_range(120)) - 60;
        default: skew = int'($urandom_range(6)) - 3;
      endcase
      rise = step + skew;
      if (rise < 0) rise = 0;
      cur_ref   = cur_ref + PosW'(step);
      cur_query = cur_query + PosW'(rise);
      rpos      = cur_ref;
      qpos      = cur_query;
    end
    send_anchor(rpos, qpos, start);
  endtask

  initial begin
    logic [BaseW-1:0] k;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    calm                  <= 1'b0;
    anchor_ch.valid       <= 1'b0;
    anchor_ch.ref_pos     <= '0;
    anchor_ch.query_pos   <= '0;
    anchor_ch.chain_start <= 1'b0;
    cur_ref   = '0;
    cur_query = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset value of base_score.
    send_anchor('0, '0, 1'b1);
    send_anchor('1, '1, 1'b0);
    send_anchor('1, '1, 1'b0);
    send_anchor('0, '1, 1'b0);
    send_anchor('1, '0, 1'b0);
    send_anchor(31'h2AAA_AAAA, 31'h5555_5555, 1'b1);
    send_anchor(31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
    // Both predecessors lie before it, but the skew penalty drives them negative.
    send_anchor(31'h5555_5556, 31'h5555_5556, 1'b0);
    // A chain one longer than the window, so the oldest entry is overwritten.
    send_anchor(31'd1, 31'd1, 1'b1);
    for (int i = 1; i <= 16; i++) begin
      send_anchor(PosW'(3 * i + 1), PosW'(4 * i + 1 - i % 3), 1'b0);
    end

    cur_ref   = PosW'($urandom);
    cur_query = PosW'($urandom);
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0:       k = 8'd255;
        1:       k = 8'd1;
        2:       k = 8'd0;
        4:       k = 8'd200;
        default: k = BaseW'($urandom_range(1, 255));
      endcase
      write_base(k);
      calm <= (p == CalmPhase);
      repeat (PhaseLen) send_random_anchor();
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
src/acs_pkg.sv
src/acs_if.sv
src/acs_cell.sv
src/acs_link.sv
src/anchor_chaining_score.sv
src/acs_checker.sv
bench/anchor_chaining_score_checker.sv
bench/anchor_chaining_score_tb.sv
